@@ sv/rrjs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_pkg - shared types and constants of the response ratio job scheduler
// Field widths, stream packing sizes, the job entry type and the sequencer
// states.
// ----------------------------------------------------------------------------
package rrjs_pkg;

   // field widths
   localparam int ID_W   = 8;
   localparam int TIME_W = 16;
   localparam int TICK_W = 21;

   // default capacity of the job store
   localparam int MAX_JOBS_DEFAULT = 16;

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 96;

   // one stored job
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
   } job_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ,
      ST_EVAL,
      ST_MUL_A,
      ST_MUL_B,
      ST_CMP,
      ST_DISPATCH
   } state_type;

endpackage

@@ sv/response_ratio_job_scheduler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// response_ratio_job_scheduler_top - highest response ratio next scheduler
// Stores jobs and emits a non-preemptive schedule when the last job of a set
// arrives.
// ----------------------------------------------------------------------------
// Job requests load the store one per cycle; a request past capacity is
// dropped, but if it is marked last the stored set is still scheduled. The
// request marked last starts scheduling and the request port stays not ready
// until the final result of the set has been handed to the output register.
// Each dispatch is one pass of a sequencer over the n stored jobs through a
// single memory read port and one shared multiplier: a job that is finished
// or not yet arrived is read and evaluated, as is the first arrived job, and
// any further arrived job is read, evaluated, given two cross products and
// compared, followed by one dispatch step, which waits while the previous
// result is still untaken. A set of n jobs takes n such passes, and one more
// pass for every idle gap in which the clock jumps to the next arrival.
// Results go out through an output register, so the scan for the next job
// proceeds while a result waits to be taken.
// ----------------------------------------------------------------------------
module response_ratio_job_scheduler_top #(
   parameter int MAX_JOBS = rrjs_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: process_id[7:0], arrival_time[23:8], burst_time[39:24]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rrjs_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              req_tlast,
   // result: job_id[7:0], start_tick[28:8], finish_tick[49:29],
   // turnaround[70:50], waiting[91:71], zeros[95:92]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rrjs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNT_W  = $clog2(MAX_JOBS + 1);
   localparam int CLK_W  = rrjs_pkg::TIME_W + CNT_W;
   localparam int RA_W   = CLK_W + 1;
   localparam int PROD_W = RA_W + rrjs_pkg::TIME_W;
   localparam int ID_W   = rrjs_pkg::ID_W;
   localparam int TIME_W = rrjs_pkg::TIME_W;
   localparam int TICK_W = rrjs_pkg::TICK_W;

   // control state
   rrjs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    issued_ff, issued_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [MAX_JOBS-1:0] done_ff, done_in;
   logic                found_ff, found_in;
   logic                min_valid_ff, min_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // scan data
   logic [CLK_W-1:0]    clock_ff, clock_in;
   logic [TIME_W-1:0]   min_arr_ff, min_arr_in;
   rrjs_pkg::job_type   best_ff, best_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [PROD_W-1:0]   lhs_ff, lhs_in;

   // result register
   logic [ID_W-1:0]     out_id_ff, out_id_in;
   logic [TICK_W-1:0]   out_start_ff, out_start_in;
   logic [TICK_W-1:0]   out_finish_ff, out_finish_in;
   logic [TICK_W-1:0]   out_turn_ff, out_turn_in;
   logic [TICK_W-1:0]   out_wait_ff, out_wait_in;
   logic                out_last_ff, out_last_in;

   // store and multiplier hookup
   rrjs_pkg::job_type   req_job;
   rrjs_pkg::job_type   rd_job;
   logic                wr_en;
   logic [RA_W-1:0]     mul_a;
   logic [TIME_W-1:0]   mul_b;
   logic [PROD_W-1:0]   prod;

   // scan helpers
   logic                last_idx;
   logic                arrived;
   logic                wins;
   logic                slot_free;
   logic [CLK_W-1:0]    finish_w;
   logic [CNT_W-1:0]    count_next;

   assign req_job.id      = req_tdata[ID_W-1:0];
   assign req_job.arrival = req_tdata[ID_W+TIME_W-1:ID_W];
   assign req_job.burst   = req_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];

   assign req_tready = (state_ff == rrjs_pkg::ST_LOAD);
   assign wr_en      = req_tvalid && req_tready && (count_ff < CNT_W'(MAX_JOBS));

   rrjs_job_store #(
      .MAX_JOBS (MAX_JOBS)
   ) u_store (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (req_job),
      .rd_addr    (idx_ff),
      .rd_data_ff (rd_job)
   );

   // operand select for the shared multiplier
   always_comb begin
      if (state_ff == rrjs_pkg::ST_MUL_A) begin
         mul_a = RA_W'(clock_ff) - RA_W'(rd_job.arrival) + RA_W'(rd_job.burst);
         mul_b = best_ff.burst;
      end else begin
         mul_a = RA_W'(clock_ff) - RA_W'(best_ff.arrival) + RA_W'(best_ff.burst);
         mul_b = rd_job.burst;
      end
   end

   rrjs_ratio_mul #(
      .A_W (RA_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // scan conditions
   assign last_idx  = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign arrived   = (CLK_W'(rd_job.arrival) <= clock_ff);
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign finish_w  = clock_ff + CLK_W'(best_ff.burst);
   assign count_next = wr_en ? count_ff + CNT_W'(1) : count_ff;

   // ranking: larger ratio, then earlier arrival, then lower id
   always_comb begin
      if (lhs_ff != prod) begin
         wins = (lhs_ff > prod);
      end else if (rd_job.arrival != best_ff.arrival) begin
         wins = (rd_job.arrival < best_ff.arrival);
      end else begin
         wins = (rd_job.id < best_ff.id);
      end
   end

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issued_in     = issued_ff;
      idx_in        = idx_ff;
      done_in       = done_ff;
      found_in      = found_ff;
      min_valid_in  = min_valid_ff;
      clock_in      = clock_ff;
      min_arr_in    = min_arr_ff;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      lhs_in        = lhs_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      out_id_in     = out_id_ff;
      out_start_in  = out_start_ff;
      out_finish_in = out_finish_ff;
      out_turn_in   = out_turn_ff;
      out_wait_in   = out_wait_ff;
      out_last_in   = out_last_ff;

      case (state_ff)
         rrjs_pkg::ST_LOAD: begin
            if (req_tvalid) begin
               count_in = count_next;
               if (req_tlast) begin
                  state_in     = rrjs_pkg::ST_READ;
                  idx_in       = '0;
                  issued_in    = '0;
                  clock_in     = '0;
                  found_in     = 1'b0;
                  min_valid_in = 1'b0;
               end
            end
         end

         rrjs_pkg::ST_READ: begin
            state_in = rrjs_pkg::ST_EVAL;
         end

         rrjs_pkg::ST_EVAL: begin
            state_in = last_idx ? rrjs_pkg::ST_DISPATCH : rrjs_pkg::ST_READ;
            if (!last_idx) begin
               idx_in = idx_ff + IDX_W'(1);
            end
            if (!done_ff[idx_ff]) begin
               if (!arrived) begin
                  // track the next arrival for an idle gap
                  if (!min_valid_ff || rd_job.arrival < min_arr_ff) begin
                     min_arr_in   = rd_job.arrival;
                     min_valid_in = 1'b1;
                  end
               end else if (!found_ff) begin
                  best_in     = rd_job;
                  best_idx_in = idx_ff;
                  found_in    = 1'b1;
               end else begin
                  state_in = rrjs_pkg::ST_MUL_A;
                  idx_in   = idx_ff;
               end
            end
         end

         rrjs_pkg::ST_MUL_A: begin
            state_in = rrjs_pkg::ST_MUL_B;
         end

         rrjs_pkg::ST_MUL_B: begin
            lhs_in   = prod;
            state_in = rrjs_pkg::ST_CMP;
         end

         rrjs_pkg::ST_CMP: begin
            if (wins) begin
               best_in     = rd_job;
               best_idx_in = idx_ff;
            end
            if (last_idx) begin
               state_in = rrjs_pkg::ST_DISPATCH;
            end else begin
               state_in = rrjs_pkg::ST_READ;
               idx_in   = idx_ff + IDX_W'(1);
            end
         end

         rrjs_pkg::ST_DISPATCH: begin
            if (!found_ff) begin
               // nothing ready: jump to the next arrival and rescan
               clock_in     = CLK_W'(min_arr_ff);
               state_in     = rrjs_pkg::ST_READ;
               idx_in       = '0;
               min_valid_in = 1'b0;
            end else if (slot_free) begin
               rsp_valid_in          = 1'b1;
               out_id_in             = best_ff.id;
               out_start_in          = TICK_W'(clock_ff);
               out_finish_in         = TICK_W'(finish_w);
               out_turn_in           = TICK_W'(finish_w - CLK_W'(best_ff.arrival));
               out_wait_in           = TICK_W'(clock_ff - CLK_W'(best_ff.arrival));
               out_last_in           = ((issued_ff + CNT_W'(1)) == count_ff);
               done_in[best_idx_ff]  = 1'b1;
               clock_in              = finish_w;
               issued_in             = issued_ff + CNT_W'(1);
               found_in              = 1'b0;
               min_valid_in          = 1'b0;
               idx_in                = '0;
               if ((issued_ff + CNT_W'(1)) == count_ff) begin
                  state_in = rrjs_pkg::ST_LOAD;
                  done_in  = '0;
                  count_in = '0;
               end else begin
                  state_in = rrjs_pkg::ST_READ;
               end
            end
         end

         default: begin
            state_in = rrjs_pkg::ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrjs_pkg::ST_LOAD;
         count_ff     <= '0;
         issued_ff    <= '0;
         idx_ff       <= '0;
         done_ff      <= '0;
         found_ff     <= 1'b0;
         min_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clock_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issued_ff    <= issued_in;
         idx_ff       <= idx_in;
         done_ff      <= done_in;
         found_ff     <= found_in;
         min_valid_ff <= min_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         clock_ff     <= clock_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      min_arr_ff    <= min_arr_in;
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      lhs_ff        <= lhs_in;
      out_id_ff     <= out_id_in;
      out_start_ff  <= out_start_in;
      out_finish_ff <= out_finish_in;
      out_turn_ff   <= out_turn_in;
      out_wait_ff   <= out_wait_in;
      out_last_ff   <= out_last_in;
   end

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {4'b0000, out_wait_ff, out_turn_ff, out_finish_ff,
                        out_start_ff, out_id_ff};

endmodule

@@ sv/rrjs_job_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_job_store - job memory
// One write port for loading jobs and one read port with registered data
// for the scan.
// ----------------------------------------------------------------------------
module rrjs_job_store #(
   parameter int MAX_JOBS = rrjs_pkg::MAX_JOBS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0] wr_addr,
   input  rrjs_pkg::job_type                        wr_data,
   input  logic [(MAX_JOBS > 1 ? $clog2(MAX_JOBS) : 1)-1:0] rd_addr,
   output rrjs_pkg::job_type                        rd_data_ff
);

   rrjs_pkg::job_type mem [MAX_JOBS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

@@ sv/rrjs_ratio_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrjs_ratio_mul - shared cross multiplication unit
// Multiplies a response term by a burst length, product registered.
// Used twice per ranking compare.
// ----------------------------------------------------------------------------
module rrjs_ratio_mul #(
   parameter int A_W = 22
) (
   input  logic                            clock,
   input  logic [A_W-1:0]                  op_a,
   input  logic [rrjs_pkg::TIME_W-1:0]     op_b,
   output logic [A_W+rrjs_pkg::TIME_W-1:0] prod_ff
);

   logic [A_W+rrjs_pkg::TIME_W-1:0] prod_in;

   // unsigned product
   assign prod_in = (A_W + rrjs_pkg::TIME_W)'(op_a) * (A_W + rrjs_pkg::TIME_W)'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule
